// ===== rtl/core/sps_pkg.sv =====
`timescale 1ns / 1ps
package sps_pkg;
  localparam int TableDepth = 16;
  localparam int MaxResults = 16;
  localparam logic [15:0] FIRST_ID = 16'd100;
  localparam logic [2:0] PRIO_MAX = 3'd4;
  localparam logic [20:0] FINISH_MAX = 21'h1FFFFF;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_ALTER  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_RUN    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SEARCH_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SORT_RD_I,
    S_SORT_RD_J,
    S_SORT_CMP,
    S_SORT_WR_J,
    S_EMIT_RD,
    S_EMIT_LATCH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [15:0] id;
    logic [2:0] prio;
    logic [15:0] cpu;
    logic [15:0] io;
  } entry_t;

  function automatic logic [2:0] clamp_prio(input logic [2:0] p);
    return (p > PRIO_MAX) ? PRIO_MAX : p;
  endfunction
endpackage

// ===== rtl/core/static_priority_process_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Insert and clear reply directly; lookup, alter and remove scan the entries one by one
// (remove then shifts the later entries down); run sorts by exchange passes of compares
// and swaps, then emits one beat per sorted entry.
// Throughput: one item at a time; in_ready stays low until its last beat has left.
// Single-port store with registered read data. Reset: table empty, next id 100.
module static_priority_process_scheduler_unit #(
  parameter int TABLE_DEPTH = sps_pkg::TableDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_target_id,
  input  logic [2:0]  in_prio_in,
  input  logic [15:0] in_cpu_in,
  input  logic [15:0] in_io_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_proc_id,
  output logic [2:0]  out_prio_out,
  output logic [15:0] out_cpu_out,
  output logic [15:0] out_io_out,
  output logic [20:0] out_finish_time,
  output logic        out_last
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EMIT_N = (TABLE_DEPTH < sps_pkg::MaxResults) ? TABLE_DEPTH
                                                              : sps_pkg::MaxResults;

  // single-port table, registered read
  sps_pkg::entry_t mem [TABLE_DEPTH];
  sps_pkg::entry_t rd_r;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  sps_pkg::entry_t wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  sps_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]   next_id_r, next_id_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;   // loop indices, wide enough to hold the count
  sps_pkg::op_t  op_r, op_nxt;
  logic [15:0]   tid_r, tid_nxt;
  logic [2:0]    prio_r, prio_nxt;
  logic [15:0]   cpu_r, cpu_nxt, io_r, io_nxt;
  sps_pkg::entry_t ei_r, ei_nxt;          // held copy of entry i during sort
  logic [20:0]   acc_r, acc_nxt;
  logic [1:0]    ost_r, ost_nxt;
  sps_pkg::entry_t oe_r, oe_nxt;
  logic [20:0]   ofin_r, ofin_nxt;
  logic          olast_r, olast_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [CW-1:0] emit_n;
  logic [21:0]   sum;

  // a new command waits until the previous reply beat has left
  assign in_ready        = (state_r == sps_pkg::S_IDLE) && !ovalid_r;
  assign out_valid       = ovalid_r;
  assign out_status      = ost_r;
  assign out_proc_id     = oe_r.id;
  assign out_prio_out    = oe_r.prio;
  assign out_cpu_out     = oe_r.cpu;
  assign out_io_out      = oe_r.io;
  assign out_finish_time = ofin_r;
  assign out_last        = olast_r;

  assign emit_n = (count_r > CW'(EMIT_N)) ? CW'(EMIT_N) : count_r;
  assign sum = {1'b0, acc_r} + 22'(rd_r.cpu) + 22'(rd_r.io);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sps_pkg::S_IDLE;
      count_r   <= '0;
      next_id_r <= sps_pkg::FIRST_ID;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
      ovalid_r  <= ovalid_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; op_r <= op_nxt; tid_r <= tid_nxt;
    prio_r <= prio_nxt; cpu_r <= cpu_nxt; io_r <= io_nxt; ei_r <= ei_nxt;
    acc_r <= acc_nxt; ost_r <= ost_nxt; oe_r <= oe_nxt; ofin_r <= ofin_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; next_id_nxt = next_id_r;
    ovalid_nxt = ovalid_r; i_nxt = i_r; j_nxt = j_r; op_nxt = op_r;
    tid_nxt = tid_r; prio_nxt = prio_r; cpu_nxt = cpu_r; io_nxt = io_r;
    ei_nxt = ei_r; acc_nxt = acc_r; ost_nxt = ost_r; oe_nxt = oe_r;
    ofin_nxt = ofin_r; olast_nxt = olast_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;

    case (state_r)
      sps_pkg::S_IDLE: begin
        if (in_valid && !ovalid_r) begin
          op_nxt   = sps_pkg::op_t'(in_opcode);
          tid_nxt  = in_target_id;
          prio_nxt = sps_pkg::clamp_prio(in_prio_in);
          cpu_nxt  = in_cpu_in;
          io_nxt   = in_io_in;
          i_nxt    = '0;
          oe_nxt   = '0; ofin_nxt = '0; olast_nxt = 1'b1; ost_nxt = sps_pkg::ST_OK;
          case (in_opcode)
            sps_pkg::OP_INSERT: begin
              if (count_r >= CW'(TABLE_DEPTH)) begin
                ost_nxt = sps_pkg::ST_FULL;
              end else begin
                we = 1'b1; waddr = count_r[AW-1:0];
                wdata = '{next_id_r, sps_pkg::clamp_prio(in_prio_in), in_cpu_in, in_io_in};
                oe_nxt = wdata;
                count_nxt = count_r + 1'b1;
                next_id_nxt = next_id_r + 16'd1;
              end
              state_nxt = sps_pkg::S_OUT;
            end
            sps_pkg::OP_LOOKUP, sps_pkg::OP_ALTER, sps_pkg::OP_REMOVE:
              state_nxt = sps_pkg::S_SEARCH;
            sps_pkg::OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = sps_pkg::S_OUT;
            end
            sps_pkg::OP_RUN: begin
              acc_nxt = '0;
              if (count_r == '0) begin
                ost_nxt = sps_pkg::ST_EMPTY;
                state_nxt = sps_pkg::S_OUT;
              end else if (count_r == CW'(1)) begin
                state_nxt = sps_pkg::S_EMIT_RD;
              end else begin
                state_nxt = sps_pkg::S_SORT_RD_I;
              end
            end
            default: ;
          endcase
        end
      end

      // linear scan for the first entry whose id matches
      sps_pkg::S_SEARCH: begin
        if (i_r >= count_r) begin
          ost_nxt = sps_pkg::ST_NOTFOUND;
          state_nxt = sps_pkg::S_OUT;
        end else begin
          raddr = i_r[AW-1:0];
          state_nxt = sps_pkg::S_SEARCH_CHK;
        end
      end
      sps_pkg::S_SEARCH_CHK: begin
        if (rd_r.id == tid_r) begin
          oe_nxt = rd_r;
          case (op_r)
            sps_pkg::OP_ALTER: begin
              oe_nxt = '{rd_r.id, prio_r, cpu_r, io_r};
              we = 1'b1; waddr = i_r[AW-1:0]; wdata = oe_nxt;
              state_nxt = sps_pkg::S_OUT;
            end
            sps_pkg::OP_REMOVE: state_nxt = sps_pkg::S_SHIFT_RD;
            default: state_nxt = sps_pkg::S_OUT;
          endcase
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = sps_pkg::S_SEARCH;
        end
      end

      // move later entries down one slot
      sps_pkg::S_SHIFT_RD: begin
        if (i_r + 1'b1 >= count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = sps_pkg::S_OUT;
        end else begin
          raddr = AW'(i_r + 1'b1);
          state_nxt = sps_pkg::S_SHIFT_WR;
        end
      end
      sps_pkg::S_SHIFT_WR: begin
        we = 1'b1; waddr = i_r[AW-1:0]; wdata = rd_r;
        i_nxt = i_r + 1'b1;
        state_nxt = sps_pkg::S_SHIFT_RD;
      end

      // exchange sort: entry i held in ei_r, j walks above it
      sps_pkg::S_SORT_RD_I: begin
        raddr = i_r[AW-1:0];
        j_nxt = i_r + 1'b1;
        state_nxt = sps_pkg::S_SORT_RD_J;
      end
      sps_pkg::S_SORT_RD_J: begin
        if (j_r == i_r + 1'b1) ei_nxt = rd_r;
        raddr = j_r[AW-1:0];
        state_nxt = sps_pkg::S_SORT_CMP;
      end
      sps_pkg::S_SORT_CMP: begin
        if (ei_r.prio > rd_r.prio) begin
          we = 1'b1; waddr = i_r[AW-1:0]; wdata = rd_r;
          oe_nxt = rd_r;   // output regs idle during sort, park new entry i there
          state_nxt = sps_pkg::S_SORT_WR_J;
        end else if (j_r + 1'b1 < count_r) begin
          j_nxt = j_r + 1'b1;
          state_nxt = sps_pkg::S_SORT_RD_J;
        end else if (i_r + 2'd2 < count_r) begin
          i_nxt = i_r + 1'b1;
          state_nxt = sps_pkg::S_SORT_RD_I;
        end else begin
          i_nxt = '0;
          state_nxt = sps_pkg::S_EMIT_RD;
        end
      end
      sps_pkg::S_SORT_WR_J: begin
        we = 1'b1; waddr = j_r[AW-1:0]; wdata = ei_r;   // ei_r still old entry i
        ei_nxt = oe_r;                                   // oe_r holds new entry i
        if (j_r + 1'b1 < count_r) begin
          j_nxt = j_r + 1'b1;
          state_nxt = sps_pkg::S_SORT_RD_J;
        end else if (i_r + 2'd2 < count_r) begin
          i_nxt = i_r + 1'b1;
          state_nxt = sps_pkg::S_SORT_RD_I;
        end else begin
          i_nxt = '0;
          state_nxt = sps_pkg::S_EMIT_RD;
        end
      end

      // emit sorted entries with running finish time
      sps_pkg::S_EMIT_RD: begin
        if (!ovalid_nxt) begin
          raddr = i_r[AW-1:0];
          state_nxt = sps_pkg::S_EMIT_LATCH;
        end
      end
      sps_pkg::S_EMIT_LATCH: begin
        oe_nxt = rd_r;
        ost_nxt = sps_pkg::ST_OK;
        acc_nxt = sum[21] ? sps_pkg::FINISH_MAX : sum[20:0];
        ofin_nxt = acc_nxt;
        olast_nxt = (i_r + 1'b1 == emit_n);
        ovalid_nxt = 1'b1;
        i_nxt = i_r + 1'b1;
        state_nxt = olast_nxt ? sps_pkg::S_IDLE : sps_pkg::S_EMIT_RD;
      end

      sps_pkg::S_OUT: begin
        if (!ovalid_nxt) begin
          ovalid_nxt = 1'b1;
          state_nxt = sps_pkg::S_IDLE;
        end
      end
      default: state_nxt = sps_pkg::S_IDLE;
    endcase
  end
endmodule
